[design/c8isc_pkg.sv]
// Package for the CHIP-8 step core: word types, command and opcode codes, font table.
package c8isc_pkg;

  localparam int MEMORY_BYTES_DEF = 4096;
  localparam int STACK_DEPTH_DEF  = 16;
  localparam int PC_LIMIT         = 4096;
  localparam logic [11:0] RESET_START = 12'h200;
  localparam int FONT_BYTES       = 80;

  typedef enum logic [1:0] {
    CMD_STEP    = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RESTART = 2'd2
  } cmd_e;

  localparam logic [3:0] FAM_SYS     = 4'h0;
  localparam logic [3:0] FAM_JP      = 4'h1;
  localparam logic [3:0] FAM_CALL    = 4'h2;
  localparam logic [3:0] FAM_SE_IMM  = 4'h3;
  localparam logic [3:0] FAM_SNE_IMM = 4'h4;
  localparam logic [3:0] FAM_SE_REG  = 4'h5;
  localparam logic [3:0] FAM_LD_IMM  = 4'h6;
  localparam logic [3:0] FAM_ADD_IMM = 4'h7;
  localparam logic [3:0] FAM_ALU     = 4'h8;
  localparam logic [3:0] FAM_SNE_REG = 4'h9;
  localparam logic [3:0] FAM_LD_IDX  = 4'hA;
  localparam logic [3:0] FAM_JP_V0   = 4'hB;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] opcode;
    logic [11:0] index_value;
    logic [7:0]  target_register;
    logic [4:0]  stack_depth;
    logic        unimplemented;
    logic        stack_overflow;
  } out_word_t;

  localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  // Power-up content of a program memory byte: font sprites low, zeros above.
  function automatic logic [7:0] init_byte(input logic [11:0] addr);
    logic [7:0] val;
    val = 8'h00;
    if (addr < 12'(FONT_BYTES)) begin
      val = FONT_ROM[addr[6:0]];
    end
    return val;
  endfunction

endpackage

[design/chip8_instruction_step_core_unit.sv]
// Top level of the CHIP-8 step core: program memory, register file and execute pipeline.
// Pipeline: a command word is fetched, then executed, and its result is registered at the output.
// Flow: the input stalls while a fetch is in flight or while the execute stage waits on a stalled
// output; a new word can be taken while the previous one executes, and its fetch takes the PC forwarded from execute.
// Reset: the program memory is rewritten with the font and zeros, one byte a cycle, over
// every address after reset; no word is accepted during that pass, though
// configuration writes are taken. Registers, index, PC and stack pointer reset at once.
module chip8_instruction_step_core_unit
  import c8isc_pkg::*;
#(
  parameter int MEMORY_BYTES = MEMORY_BYTES_DEF,
  parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW  = $clog2(MEMORY_BYTES);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPX = (SPW > 5) ? SPW : 5;

  // Storage: program memory with two read ports, register file with two read ports,
  // and the return stack, which only ever takes pushes.
  logic [7:0]  pmem [MEMORY_BYTES];
  logic [7:0]  vmem [16];
  logic [11:0] stack_mem [STACK_DEPTH];
  logic [15:0] vvalid_q;

  // Architectural registers.
  logic [11:0]    pc_q, idx_q, start_q;
  logic [SPW-1:0] sp_q;

  // Power-up clearing pass over the program memory.
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  // Pipeline: fetch stage (memory read in flight) and execute stage.
  logic        f_q, e_q;
  logic [1:0]  cmd_f_q, cmd_e_q;
  logic [7:0]  hi_rd_q, lo_rd_q;
  logic        hi_ok_q, lo_ok_q;
  logic [15:0] op_q;
  logic [7:0]  vx_rd_q, vy_rd_q;
  logic        vx_ok_q, vy_ok_q;

  logic      out_valid_q;
  out_word_t out_q;

  // Handshake.
  logic out_free, e_done, accept;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign e_done     = e_q && out_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = clr_q || f_q || (e_q && !out_free);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Configuration port: one register, the restart address.
  assign pready = 1'b1;
  assign prdata = {20'd0, start_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= RESET_START;
    end else if (psel && penable && pwrite && pready && (paddr <= 2'd3)) begin
      start_q <= pwdata[11:0];
    end
  end

  // Execute stage. The opcode fields come from the registered fetch, the register
  // operands from the registered register-file read; invalid entries read as zero.
  logic [3:0]     fam, vx_sel;
  logic [11:0]    nnn;
  logic [7:0]     kk, vx, vy, vx_new;
  logic [12:0]    pc_plus2, npc;
  logic [11:0]    pc_d, idx_d;
  logic [SPW-1:0] sp_d;
  logic           stack_full, push, v_we, unimpl, ovf;
  logic [SPX-1:0] sp_ext;
  out_word_t      res;

  assign fam        = op_q[15:12];
  assign vx_sel     = op_q[11:8];
  assign nnn        = op_q[11:0];
  assign kk         = op_q[7:0];
  assign vx         = vx_ok_q ? vx_rd_q : 8'h00;
  assign vy         = vy_ok_q ? vy_rd_q : 8'h00;
  assign pc_plus2   = {1'b0, pc_q} + 13'd2;
  assign stack_full = !(sp_q < SPW'(STACK_DEPTH));

  always_comb begin
    pc_d   = pc_q;
    idx_d  = idx_q;
    sp_d   = sp_q;
    npc    = pc_plus2;
    vx_new = vx;
    push   = 1'b0;
    v_we   = 1'b0;
    unimpl = 1'b0;
    ovf    = 1'b0;
    if (e_q) begin
      case (cmd_e_q)
        CMD_STEP: begin
          case (fam)
            FAM_SYS, FAM_ALU: begin
              npc    = {1'b0, pc_q};
              unimpl = 1'b1;
            end
            FAM_JP: npc = {1'b0, nnn};
            FAM_CALL: begin
              npc = {1'b0, nnn};
              if (stack_full) begin
                ovf = 1'b1;
              end else begin
                push = 1'b1;
                sp_d = sp_q + SPW'(1);
              end
            end
            FAM_SE_IMM:  if (vx == kk) npc = pc_plus2 + 13'd2;
            FAM_SNE_IMM: if (vx != kk) npc = pc_plus2 + 13'd2;
            FAM_SE_REG:  if (vx == vy) npc = pc_plus2 + 13'd2;
            FAM_SNE_REG: if (vx != vy) npc = pc_plus2 + 13'd2;
            FAM_LD_IMM: begin
              vx_new = kk;
              v_we   = 1'b1;
            end
            FAM_ADD_IMM: begin
              vx_new = vx + kk;
              v_we   = 1'b1;
            end
            FAM_LD_IDX: idx_d = nnn;
            FAM_JP_V0:  npc = {1'b0, nnn} + {5'd0, vy};
            default: unimpl = 1'b1;
          endcase
          // A program counter past the address space restarts at the start address.
          if (npc >= 13'(PC_LIMIT)) begin
            pc_d = start_q;
          end else begin
            pc_d = npc[11:0];
          end
        end
        CMD_RESTART: begin
          pc_d  = start_q;
          idx_d = 12'd0;
          sp_d  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign sp_ext = SPX'(sp_d);

  always_comb begin
    res                 = '0;
    res.program_counter = pc_d;
    res.index_value     = idx_d;
    res.stack_depth     = sp_ext[4:0];
    if (cmd_e_q == CMD_STEP) begin
      res.opcode          = op_q;
      res.target_register = vx_new;
      res.unimplemented   = unimpl;
      res.stack_overflow  = ovf;
    end
  end

  // A step accepted while the previous word finishes fetches at that word's new PC.
  logic [11:0] fetch_addr;
  logic [12:0] fetch_addr_lo;
  logic        mem_we;
  logic [11:0] mem_wa;
  logic [7:0]  mem_wd;
  logic        wr_ok;

  assign fetch_addr    = e_q ? pc_d : pc_q;
  assign fetch_addr_lo = {1'b0, fetch_addr} + 13'd1;
  assign wr_ok         = {1'b0, in_word_i.address} < 13'(MEMORY_BYTES);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = in_word_i.address;
    mem_wd = in_word_i.data;
    if (clr_q) begin
      mem_we = 1'b1;
      mem_wa = 12'(clr_cnt_q);
      mem_wd = init_byte(12'(clr_cnt_q));
    end else if (accept && (in_word_i.command == CMD_WRITE) && wr_ok) begin
      mem_we = 1'b1;
    end
  end

  // Program memory: one write port, two registered read ports for the opcode bytes.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      pmem[mem_wa[AW-1:0]] <= mem_wd;
    end
    if (accept) begin
      hi_rd_q <= pmem[fetch_addr[AW-1:0]];
      lo_rd_q <= pmem[fetch_addr_lo[AW-1:0]];
      hi_ok_q <= {1'b0, fetch_addr} < 13'(MEMORY_BYTES);
      lo_ok_q <= fetch_addr_lo < 13'(MEMORY_BYTES);
      cmd_f_q <= in_word_i.command;
    end
  end

  // Fetch stage: assemble the opcode and read registers X and Y (V0 for jump plus V0).
  logic [7:0] hi_b, lo_b;
  logic [3:0] vy_sel;
  assign hi_b   = hi_ok_q ? hi_rd_q : 8'h00;
  assign lo_b   = lo_ok_q ? lo_rd_q : 8'h00;
  assign vy_sel = (hi_b[7:4] == FAM_JP_V0) ? 4'h0 : lo_b[7:4];

  always_ff @(posedge clk_i) begin
    if (e_done && v_we) begin
      vmem[vx_sel] <= vx_new;
    end
    if (f_q) begin
      op_q    <= {hi_b, lo_b};
      cmd_e_q <= cmd_f_q;
      vx_rd_q <= vmem[hi_b[3:0]];
      vy_rd_q <= vmem[vy_sel];
      vx_ok_q <= vvalid_q[hi_b[3:0]];
      vy_ok_q <= vvalid_q[vy_sel];
    end
  end

  // Return stack: a call pushes the address of the following instruction.
  always_ff @(posedge clk_i) begin
    if (e_done && push) begin
      stack_mem[sp_q[SAW-1:0]] <= pc_plus2[11:0];
    end
  end

  // Output register holds the result word until it is taken.
  always_ff @(posedge clk_i) begin
    if (e_done) begin
      out_q <= res;
    end
  end

  // Control state: pipeline valids, architectural registers, register valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      f_q         <= 1'b0;
      e_q         <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= RESET_START;
      idx_q       <= 12'd0;
      sp_q        <= '0;
      vvalid_q    <= '0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(MEMORY_BYTES - 1)) begin
          clr_q <= 1'b0;
        end
      end
      f_q <= accept;
      e_q <= f_q || (e_q && !out_free);
      if (e_done) begin
        out_valid_q <= 1'b1;
        pc_q        <= pc_d;
        idx_q       <= idx_d;
        sp_q        <= sp_d;
        if (cmd_e_q == CMD_RESTART) begin
          vvalid_q <= '0;
        end else if (v_we) begin
          vvalid_q[vx_sel] <= 1'b1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[bench/step_result_checker.sv]
// Checker for the CHIP-8 step core: tracks the core's state and compares every result word.
module step_result_checker
  import c8isc_pkg::*;
#(
  parameter logic [1:0] START_REG_ADDR = 2'd0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [1:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          error_count_o,
  output int          pending_o
);

  localparam int CODE_BYTES = 4096;
  localparam int RET_DEPTH  = 16;
  localparam int ADDR_SPACE = 4096;
  localparam int SPRITE_LEN = 80;

  localparam logic [7:0] SPRITE_BYTES [SPRITE_LEN] = '{
    8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
    8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
    8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
    8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
  };

  logic [7:0]  code_mem [CODE_BYTES];
  logic [7:0]  v_regs [16];
  logic [11:0] index_q;
  logic [11:0] pc_q;
  logic [11:0] start_q;
  int          call_depth;
  out_word_t   expected_words [$];
  out_word_t   oldest;
  int          k;

  initial error_count_o = 0;

  function automatic logic [7:0] fetch_byte(input int addr);
    return (addr < CODE_BYTES) ? code_mem[addr] : 8'h00;
  endfunction

  // Applies one command word to the tracked state and returns the word the core should send.
  function automatic out_word_t execute_word(input in_word_t w);
    out_word_t   res;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [11:0] nnn;
    int          npc;
    res = '0;
    case (w.command)
      CMD_WRITE: begin
        if (int'(w.address) < CODE_BYTES) begin
          code_mem[w.address] = w.data;
        end
      end
      CMD_RESTART: begin
        v_regs     = '{default: 8'h00};
        index_q    = '0;
        call_depth = 0;
        pc_q       = start_q;
      end
      CMD_STEP: begin
        hi  = fetch_byte(int'(pc_q));
        lo  = fetch_byte(int'(pc_q) + 1);
        x   = hi[3:0];
        y   = lo[7:4];
        nnn = {hi[3:0], lo};
        npc = int'(pc_q) + 2;
        res.opcode = {hi, lo};
        case (hi[7:4])
          FAM_SYS, FAM_ALU: begin
            npc = int'(pc_q);
            res.unimplemented = 1'b1;
          end
          FAM_JP: npc = int'(nnn);
          FAM_CALL: begin
            // A full stack drops the push but the jump is still taken.
            if (call_depth < RET_DEPTH) begin
              call_depth++;
            end else begin
              res.stack_overflow = 1'b1;
            end
            npc = int'(nnn);
          end
          FAM_SE_IMM:  if (v_regs[x] == lo) npc += 2;
          FAM_SNE_IMM: if (v_regs[x] != lo) npc += 2;
          FAM_SE_REG:  if (v_regs[x] == v_regs[y]) npc += 2;
          FAM_SNE_REG: if (v_regs[x] != v_regs[y]) npc += 2;
          FAM_LD_IMM:  v_regs[x] = lo;
          FAM_ADD_IMM: v_regs[x] = v_regs[x] + lo;
          FAM_LD_IDX:  index_q = nnn;
          FAM_JP_V0:   npc = int'(nnn) + int'(v_regs[0]);
          default:     res.unimplemented = 1'b1;
        endcase
        if (npc >= ADDR_SPACE) begin
          npc = int'(start_q);
        end
        pc_q = 12'(npc);
        res.target_register = v_regs[x];
      end
      default: ;
    endcase
    res.program_counter = pc_q;
    res.index_value     = index_q;
    res.stack_depth     = 5'(call_depth);
    return res;
  endfunction

  task automatic report_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (k = 0; k < CODE_BYTES; k++) begin
        code_mem[k] = (k < SPRITE_LEN) ? SPRITE_BYTES[k] : 8'h00;
      end
      v_regs     = '{default: 8'h00};
      index_q    = '0;
      pc_q       = 12'h200;
      start_q    = 12'h200;
      call_depth = 0;
      expected_words.delete();
      pending_o  = 0;
    end else begin
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_words.size() == 0) begin
          $error("result word %0h arrived with nothing expected", out_word_i);
          error_count_o++;
        end else begin
          oldest = expected_words.pop_front();
          report_field("program_counter", 16'(oldest.program_counter),
                       16'(out_word_i.program_counter));
          report_field("opcode", oldest.opcode, out_word_i.opcode);
          report_field("index_value", 16'(oldest.index_value), 16'(out_word_i.index_value));
          report_field("target_register", 16'(oldest.target_register),
                       16'(out_word_i.target_register));
          report_field("stack_depth", 16'(oldest.stack_depth), 16'(out_word_i.stack_depth));
          report_field("unimplemented", 16'(oldest.unimplemented),
                       16'(out_word_i.unimplemented));
          report_field("stack_overflow", 16'(oldest.stack_overflow),
                       16'(out_word_i.stack_overflow));
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == START_REG_ADDR) begin
        start_q = pwdata_i[11:0];
      end
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0) begin
        expected_words.push_back(execute_word(in_word_i));
      end
      pending_o = expected_words.size();
    end
  end

endmodule

[bench/testbench.sv]
// Testbench top for the CHIP-8 step core: clock, reset, stimulus, idling and the verdict.
module testbench;
  import c8isc_pkg::*;

  // The start address register is the only register; the core decodes no address bits, and the bench uses zero.
  localparam logic [1:0] START_REG_ADDR = 2'd0;
  // The command field has a fourth encoding that the core must treat as a no-op.
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         CYCLE_LIMIT    = 600000;
  localparam int         PHASE_WORDS    = 250;
  localparam int         LONG_HOLD      = 300;
  localparam int         SETTLE_CYCLES  = 8;
  localparam int         PHASES         = 8;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_word;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          error_count;
  int          pending_words;
  int          cycle_count = 0;
  int          words_sent = 0;
  // Odds of an idle burst: one chance in N per word or per cycle; zero turns idling off.
  int          gap_odds = 0;
  int          stall_odds = 0;
  logic        hold_request = 1'b0;
  // Mirror of the start address, so that programs are written where a restart lands.
  logic [11:0] start_addr = 12'h200;

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  chip8_instruction_step_core_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  step_result_checker #(
    .START_REG_ADDR (START_REG_ADDR)
  ) result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .error_count_o (error_count),
    .pending_o     (pending_words)
  );

  // Offers one command word and returns at the edge where the core takes it. Valid is left
  // high afterwards, so that back-to-back words never drop it in between; it only falls
  // when an idle burst starts or when the sender waits for the core to drain.
  task automatic send_word(input logic [1:0] cmd, input logic [11:0] addr,
                           input logic [7:0] data);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_word  <= '{command: cmd, address: addr, data: data};
    @(posedge clk_i);
    // An unknown stall during the memory clearing pass is treated like a stall.
    while (in_stall !== 1'b0) @(posedge clk_i);
    words_sent++;
  endtask

  // Drops valid and waits until every expected result word has come back. The count is
  // sampled on the falling edge, away from the edge where the checker updates it.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_words != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the write lands on the edge with penable and pready.
  task automatic write_start_address(input logic [11:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_REG_ADDR;
    pwdata  <= {20'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    start_addr = value;
  endtask

  // Random traffic. Most of it is small programs: a restart that puts PC on the start
  // address, a handful of opcodes written from there on, and a run of steps over them.
  // Jumps, calls and index loads mostly point back into the program so that execution
  // stays inside it for a while. Some sequences are a single call to itself, which keeps
  // pushing until the stack runs full. The rest is random noise words, and now and then
  // a program whose restart is left out, so that PC starts wherever the last run left it.
  task automatic run_phase(input int count);
    int          goal;
    int          kind;
    int          n;
    int          steps;
    int          i;
    logic [3:0]  fam;
    logic [7:0]  kk;
    logic [11:0] target;
    logic [11:0] spot;
    logic [15:0] opc;
    goal = words_sent + count;
    while (words_sent < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send_word(2'($urandom), 12'($urandom), 8'($urandom));
      end else begin
        if ($urandom_range(0, 9) != 0) begin
          send_word(CMD_RESTART, 12'($urandom), 8'($urandom));
        end
        if (kind < 22) begin
          send_word(CMD_WRITE, start_addr, {FAM_CALL, start_addr[11:8]});
          send_word(CMD_WRITE, start_addr + 12'd1, start_addr[7:0]);
          steps = $urandom_range(16, 20);
        end else begin
          n = $urandom_range(2, 10);
          for (i = 0; i < n; i++) begin
            fam = 4'($urandom);
            // Families that hold PC end the run, so they are made rarer.
            if ((fam == FAM_SYS || fam == FAM_ALU) && $urandom_range(0, 3) != 0) begin
              fam = FAM_ADD_IMM;
            end
            // Small immediates often match registers that a restart has cleared.
            kk = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            target = start_addr + 12'(2 * $urandom_range(0, n - 1));
            if ($urandom_range(0, 7) == 0) begin
              target = 12'($urandom);
            end
            case (fam)
              FAM_JP, FAM_CALL, FAM_LD_IDX: opc = {fam, target};
              FAM_JP_V0: opc = {fam, target - 12'($urandom_range(0, 4))};
              FAM_SE_REG, FAM_SNE_REG: opc = {fam, 4'($urandom), 4'($urandom), 4'($urandom)};
              default: opc = {fam, 4'($urandom), kk};
            endcase
            spot = start_addr + 12'(2 * i);
            send_word(CMD_WRITE, spot, opc[15:8]);
            send_word(CMD_WRITE, spot + 12'd1, opc[7:0]);
          end
          steps = $urandom_range(n, 3 * n);
        end
        repeat (steps) send_word(CMD_STEP, 12'($urandom), 8'($urandom));
      end
    end
  endtask

  // The receiver idles in random bursts. A hold request from the stimulus makes it stall
  // for a long stretch while the sender keeps offering words, so the core backs up.
  initial begin : receiver
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall    <= 1'b0;
        hold_request = 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("** chip8_instruction_step_core_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int          p;
    logic [11:0] phase_start [PHASES];
    int          phase_gaps [PHASES];
    int          phase_stalls [PHASES];
    rst_ni   <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Configuration writes are taken during the memory clearing pass that follows reset.
    write_start_address(RESET_START);

    // Directed words, run without idling. The unused command must change nothing.
    send_word(CMD_UNUSED, 12'hFFF, 8'hFF);
    // Memory above the font is zero, so this step decodes family 0 and PC holds.
    send_word(CMD_STEP, 12'h000, 8'h00);
    // LD V0, 0xFF followed by JP V0 + 0xF50, whose target overflows back to the start.
    send_word(CMD_WRITE, 12'h200, 8'h60);
    send_word(CMD_WRITE, 12'h201, 8'hFF);
    send_word(CMD_WRITE, 12'h202, 8'hBF);
    send_word(CMD_WRITE, 12'h203, 8'h50);
    send_word(CMD_STEP, 12'h000, 8'h00);
    send_word(CMD_STEP, 12'h000, 8'h00);
    // JP 0xFFF reaches the last byte; the step there fetches its low byte past the end of
    // memory, reads zero, and the advanced PC overflows back to the start address.
    send_word(CMD_WRITE, 12'h200, 8'h1F);
    send_word(CMD_WRITE, 12'h201, 8'hFF);
    send_word(CMD_STEP, 12'h000, 8'h00);
    send_word(CMD_WRITE, 12'hFFF, 8'hFF);
    send_word(CMD_STEP, 12'hFFF, 8'hFF);
    // Lowest address and data; this overwrites the first font byte.
    send_word(CMD_WRITE, 12'h000, 8'h00);
    // Restart clears V0 and the index but keeps memory, so the jump program runs again.
    send_word(CMD_RESTART, 12'h000, 8'h00);
    send_word(CMD_STEP, 12'h000, 8'h00);
    send_word(CMD_STEP, 12'h000, 8'h00);

    // Each phase runs from another start address, the extremes among them, with its own
    // mix of idling. The last phase runs with no idling at all.
    phase_start  = '{12'h000, 12'hFFF, 12'hFFE, 12'h200, 12'($urandom), 12'hF00,
                     12'($urandom), 12'h200};
    phase_gaps   = '{4, 0, 9, 3, 6, 14, 5, 0};
    phase_stalls = '{5, 9, 0, 4, 7, 3, 12, 0};
    for (p = 0; p < PHASES; p++) begin
      wait_idle();
      write_start_address(phase_start[p]);
      gap_odds   = phase_gaps[p];
      stall_odds = phase_stalls[p];
      if (p == 3) begin
        // Long receiver hold while words keep coming: the core fills and stalls its input.
        hold_request = 1'b1;
      end
      if (p == 5) begin
        // Midway the sender stops until every result word is back, then carries on.
        run_phase(PHASE_WORDS / 2);
        wait_idle();
        run_phase(PHASE_WORDS / 2);
      end else begin
        run_phase(PHASE_WORDS);
      end
    end

    wait_idle();
    if (error_count == 0 && pending_words == 0) begin
      $display("** chip8_instruction_step_core_unit: PASSED **");
    end else begin
      $display("** chip8_instruction_step_core_unit: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
design/c8isc_pkg.sv
design/chip8_instruction_step_core_unit.sv
bench/step_result_checker.sv
bench/testbench.sv
